### rtl/c8ie_pkg.sv
// Package of shared types and constants for the CHIP-8 execution core.
package c8ie_pkg;

    // Sizes of the data memory and the return stack
    localparam int MEM_DEPTH   = 4096;
    localparam int STACK_DEPTH = 16;

    // Configuration register indexes
    localparam logic [1:0] REG_START_PC  = 2'd0;
    localparam logic [1:0] REG_FONT_BASE = 2'd1;
    localparam logic [1:0] REG_FONT_ROWS = 2'd2;

    // Datapath commands from the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_EXEC,
        CMD_MEM_WRITE,
        CMD_BCD_STEP,
        CMD_STORE_STEP,
        CMD_LOAD_ADDR,
        CMD_LOAD_STEP,
        CMD_FINISH
    } t_cmd;

    // Status from the datapath back to the controller
    typedef struct packed {
        logic is_write;
        logic is_bcd;
        logic is_store;
        logic is_load;
        logic last_step;
    } t_status;

    // Input item
    typedef struct packed {
        logic        mode;
        logic [15:0] opcode;
        logic [15:0] key_state;
        logic [7:0]  random_byte;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic        clear_request;
        logic        draw_request;
        logic [7:0]  draw_x;
        logic [7:0]  draw_y;
        logic [3:0]  draw_rows;
        logic        wait_key;
        logic [3:0]  wait_target;
        logic [7:0]  delay_value;
        logic [7:0]  sound_value;
    } t_out_item;

endpackage

### rtl/c8ie_if.sv
// Valid/ready channel interface carrying one item.
interface c8ie_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/c8ie_ctrl.sv
// Controller state machine sequencing each item through the datapath.
module c8ie_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  c8ie_pkg::t_status i_status,
    output c8ie_pkg::t_cmd    o_cmd
);
    import c8ie_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_BCD   = 7'b0000100,
        ST_STORE = 7'b0001000,
        ST_LADDR = 7'b0010000,
        ST_LDATA = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // The result register may be taken while the next item is waiting.
    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = CMD_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd   = CMD_CAPTURE;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_write) begin
                    o_cmd   = CMD_MEM_WRITE;
                    n_state = ST_DONE;
                end else if (i_status.is_bcd) begin
                    n_state = ST_BCD;
                end else if (i_status.is_store) begin
                    n_state = ST_STORE;
                end else if (i_status.is_load) begin
                    n_state = ST_LADDR;
                end else begin
                    o_cmd   = CMD_EXEC;
                    n_state = ST_DONE;
                end
            end
            ST_BCD: begin
                o_cmd = CMD_BCD_STEP;
                if (i_status.last_step) n_state = ST_DONE;
            end
            ST_STORE: begin
                o_cmd = CMD_STORE_STEP;
                if (i_status.last_step) n_state = ST_DONE;
            end
            ST_LADDR: begin
                o_cmd   = CMD_LOAD_ADDR;
                n_state = ST_LDATA;
            end
            ST_LDATA: begin
                o_cmd   = CMD_LOAD_STEP;
                n_state = i_status.last_step ? ST_DONE : ST_LADDR;
            end
            ST_DONE: begin
                o_cmd       = CMD_FINISH;
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // An item is only taken when no result is pending.
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready) else $error("accept with pending result");
    // A finished item always raises the result valid.
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> r_out_valid) else $error("result not raised");
    // Work starts only from an accepted item.
    a_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $past(i_in_valid && o_in_ready))
        else $error("execution without item");
endmodule

### rtl/c8ie_dpath.sv
// Datapath: architectural registers, return stack, data memory and result register.
module c8ie_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  c8ie_pkg::t_cmd       i_cmd,
    output c8ie_pkg::t_status    o_status,
    input  c8ie_pkg::t_in_item   i_item,
    output c8ie_pkg::t_out_item  o_result,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data,
    output logic [11:0]          o_start_pc,
    output logic [11:0]          o_font_base,
    output logic [4:0]           o_font_rows
);
    import c8ie_pkg::*;

    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SW = $clog2(STACK_DEPTH);

    // Configuration and architectural state
    logic [11:0] r_start_pc, r_font_base;
    logic [4:0]  r_font_rows;
    logic [7:0]  r_v [16];
    logic [15:0] r_i;
    logic [11:0] r_pc;
    logic [SW-1:0] r_sp;
    logic [7:0]  r_dt, r_st;
    logic [11:0] r_stack [STACK_DEPTH];
    logic [7:0]  r_mem [MEM_DEPTH];
    logic [7:0]  r_rdata;

    // Captured item and step counter
    t_in_item    r_item;
    logic [3:0]  r_step;
    t_out_item   r_res;

    logic [15:0] op;
    logic [3:0]  xi, yi, n;
    logic [7:0]  nn, vx, vy;
    logic [11:0] nnn;
    assign op  = r_item.opcode;
    assign xi  = op[11:8];
    assign yi  = op[7:4];
    assign n   = op[3:0];
    assign nn  = op[7:0];
    assign nnn = op[11:0];
    assign vx  = r_v[xi];
    assign vy  = r_v[yi];

    assign o_start_pc  = r_start_pc;
    assign o_font_base = r_font_base;
    assign o_font_rows = r_font_rows;
    assign o_result    = r_res;

    // Decode classes for the multi-cycle operations
    assign o_status.is_write = r_item.mode;
    assign o_status.is_bcd   = (op[15:12] == 4'hF) && (nn == 8'h33);
    assign o_status.is_store = (op[15:12] == 4'hF) && (nn == 8'h55);
    assign o_status.is_load  = (op[15:12] == 4'hF) && (nn == 8'h65);
    assign o_status.last_step = o_status.is_bcd ? (r_step == 4'd2) : (r_step == xi);

    // BCD digits of VX, digit picked by the step counter
    logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_rem, bcd_digit;
    logic [13:0] bcd_prod;
    always_comb begin
        bcd_h   = (vx >= 8'd200) ? 8'd2 : ((vx >= 8'd100) ? 8'd1 : 8'd0);
        bcd_rem = vx - bcd_h * 8'd100;
        // Tens of a value below 100 by multiplying with 103/1024
        bcd_prod = {7'd0, bcd_rem[6:0]} * 14'd103;
        bcd_t    = {4'd0, bcd_prod[13:10]};
        bcd_o    = bcd_rem - bcd_t * 8'd10;
        unique case (r_step[1:0])
            2'd0:    bcd_digit = bcd_h;
            2'd1:    bcd_digit = bcd_t;
            default: bcd_digit = bcd_o;
        endcase
    end

    // Memory write port and registered read
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_i[AW-1:0];
        mem_wd = r_v[r_step];
        unique case (i_cmd)
            CMD_MEM_WRITE: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_item.mem_address);
                mem_wd = r_item.mem_data;
            end
            CMD_BCD_STEP: begin
                mem_we = 1'b1;
                mem_wd = bcd_digit;
            end
            CMD_STORE_STEP: mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata <= r_mem[r_i[AW-1:0]];
    end

    // ALU result and skip condition for the register-writing and skip opcodes
    logic       v_we, f_we;
    logic [7:0] v_val, f_val;
    logic [8:0] sum;
    logic       key_hit;
    logic       skip;
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign key_hit = (vx[7:4] == 4'd0) && r_item.key_state[4'd15 - vx[3:0]];

    always_comb begin
        v_we  = 1'b0;
        f_we  = 1'b0;
        v_val = 8'd0;
        f_val = 8'd0;
        skip  = 1'b0;
        unique case (op[15:12])
            4'h3: skip = (vx == nn);
            4'h4: skip = (vx != nn);
            4'h5: skip = (n == 4'd0) && (vx == vy);
            4'h6: begin v_we = 1'b1; v_val = nn; end
            4'h7: begin v_we = 1'b1; v_val = vx + nn; end
            4'h8: begin
                unique case (n)
                    4'h0: begin v_we = 1'b1; v_val = vy; end
                    4'h1: begin v_we = 1'b1; v_val = vx | vy; end
                    4'h2: begin v_we = 1'b1; v_val = vx & vy; end
                    4'h3: begin v_we = 1'b1; v_val = vx ^ vy; end
                    4'h4: begin
                        v_we = 1'b1; v_val = sum[7:0];
                        f_we = 1'b1; f_val = {7'd0, sum[8]};
                    end
                    4'h5: begin
                        v_we = 1'b1; v_val = vx - vy;
                        f_we = 1'b1; f_val = {7'd0, vx >= vy};
                    end
                    4'h6: begin
                        v_we = 1'b1; v_val = {1'b0, vx[7:1]};
                        f_we = 1'b1; f_val = {7'd0, vx[0]};
                    end
                    4'h7: begin
                        v_we = 1'b1; v_val = vy - vx;
                        f_we = 1'b1; f_val = {7'd0, vy >= vx};
                    end
                    4'hE: begin
                        v_we = 1'b1; v_val = {vx[6:0], 1'b0};
                        f_we = 1'b1; f_val = {7'd0, vx[7]};
                    end
                    default: v_we = 1'b0;
                endcase
            end
            4'h9: skip = (n == 4'd0) && (vx != vy);
            4'hC: begin v_we = 1'b1; v_val = r_item.random_byte & nn; end
            4'hE: begin
                if (nn == 8'h9E) skip = key_hit;
                else if (nn == 8'hA1) skip = !key_hit;
            end
            4'hF: begin
                if (nn == 8'h07) begin v_we = 1'b1; v_val = r_dt; end
            end
            default: skip = 1'b0;
        endcase
    end

    // Font address product
    logic [15:0] font_addr;
    assign font_addr = 16'(vx * r_font_rows) + {4'd0, r_font_base};

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc  <= 12'd512;
            r_font_base <= 12'd0;
            r_font_rows <= 5'd5;
            r_pc        <= 12'd512;
            r_i         <= 16'd0;
            r_sp        <= SW'(STACK_DEPTH - 1);
            r_dt        <= 8'd0;
            r_st        <= 8'd0;
            r_step      <= 4'd0;
            for (int k = 0; k < 16; k++) r_v[k] <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START_PC: begin
                        r_start_pc <= i_cfg_data[11:0];
                        r_pc       <= i_cfg_data[11:0];
                    end
                    REG_FONT_BASE: r_font_base <= i_cfg_data[11:0];
                    REG_FONT_ROWS: r_font_rows <= i_cfg_data[4:0];
                    default: r_font_rows <= r_font_rows;
                endcase
            end
            unique case (i_cmd)
                CMD_CAPTURE: begin
                    r_item <= i_item;
                    r_step <= 4'd0;
                end
                CMD_EXEC: begin
                    if (v_we) r_v[xi] <= v_val;
                    if (f_we) r_v[15] <= f_val;
                    if (skip) r_pc <= r_pc + 12'd2;
                    unique case (op[15:12])
                        4'h0: begin
                            if (op == 16'h00EE) begin
                                r_pc <= r_stack[r_sp];
                                r_sp <= r_sp - SW'(1);
                            end
                        end
                        4'h1: r_pc <= nnn;
                        4'h2: begin
                            r_sp <= r_sp + SW'(1);
                            r_stack[r_sp + SW'(1)] <= r_pc;
                            r_pc <= nnn;
                        end
                        4'hA: r_i <= {4'd0, nnn};
                        4'hB: r_pc <= {4'd0, r_v[0]} + nnn;
                        4'hF: begin
                            if (nn == 8'h15) r_dt <= vx;
                            else if (nn == 8'h18) r_st <= vx;
                            else if (nn == 8'h1E) r_i <= r_i + {8'd0, vx};
                            else if (nn == 8'h29) r_i <= font_addr;
                        end
                        default: r_step <= r_step;
                    endcase
                end
                CMD_BCD_STEP: begin
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd2) r_i <= r_i - 16'd2;
                    else r_i <= r_i + 16'd1;
                end
                CMD_STORE_STEP: begin
                    r_step <= r_step + 4'd1;
                    r_i    <= r_i + 16'd1;
                end
                CMD_LOAD_STEP: begin
                    r_v[r_step] <= r_rdata;
                    r_step      <= r_step + 4'd1;
                    r_i         <= r_i + 16'd1;
                end
                default: r_step <= r_step;
            endcase
        end
    end

    // Result register, filled once the item has finished
    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_FINISH) begin
            r_res.next_pc       <= r_pc;
            r_res.index_value   <= r_i;
            r_res.delay_value   <= r_dt;
            r_res.sound_value   <= r_st;
            r_res.clear_request <= !r_item.mode && (op == 16'h00E0);
            r_res.draw_request  <= !r_item.mode && (op[15:12] == 4'hD);
            r_res.draw_x        <= (!r_item.mode && op[15:12] == 4'hD) ? vx : 8'd0;
            r_res.draw_y        <= (!r_item.mode && op[15:12] == 4'hD) ? vy : 8'd0;
            r_res.draw_rows     <= (!r_item.mode && op[15:12] == 4'hD) ? n : 4'd0;
            r_res.wait_key      <= !r_item.mode && (op[15:12] == 4'hF) && (nn == 8'h0A);
            r_res.wait_target   <= (!r_item.mode && op[15:12] == 4'hF && nn == 8'h0A)
                                   ? xi : 4'd0;
        end
    end

    // A BCD run never takes more than three steps.
    a_bcd_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_BCD_STEP) |-> (r_step <= 4'd2)) else $error("BCD overrun");
    // A call moves the stack pointer up by one.
    a_call_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_EXEC && op[15:12] == 4'h2 && !i_cfg_we) |=>
        (r_sp == $past(r_sp) + SW'(1))) else $error("stack pointer slip");
    // Block transfers never go past register X.
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_STORE_STEP || i_cmd == CMD_LOAD_STEP) |-> (r_step <= xi))
        else $error("block transfer overrun");
endmodule

### rtl/chip8_instruction_execute.sv
// Top level of the CHIP-8 instruction execution core.
// One item is taken at a time. A write item or a simple opcode passes through the execute
// and done states; FX33 steps through its three BCD digits, FX55 stores registers V0 to VX
// one byte a cycle, and FX65 alternates an address and a data state for each register,
// since the read data of the data memory is registered. The next item is taken in the cycle
// after the result has been delivered.
// Configuration is written through the APB port: start_pc at 0x0, font_base at 0x4 and
// font_rows at 0x8; writing start_pc also loads the program counter.
module chip8_instruction_execute (
    input  logic        i_clk,
    input  logic        i_rst_n,
    c8ie_if.sink        i_in,
    c8ie_if.source      o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import c8ie_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic        cfg_we;
    logic [11:0] start_pc, font_base;
    logic [4:0]  font_rows;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // Register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_START_PC:  prdata = {20'd0, start_pc};
            REG_FONT_BASE: prdata = {20'd0, font_base};
            REG_FONT_ROWS: prdata = {27'd0, font_rows};
            default:       prdata = 32'd0;
        endcase
    end

    c8ie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    c8ie_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in.payload),
        .o_result    (o_out.payload),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (paddr[3:2]),
        .i_cfg_data  (pwdata),
        .o_start_pc  (start_pc),
        .o_font_base (font_base),
        .o_font_rows (font_rows)
    );
endmodule
